// ===== rtl/core/ssba_pkg.sv =====
package ssba_pkg;

  // fixed geometry of one stack slot
  localparam int          PAGE_BYTES     = 4096;
  localparam int          PAGE_SHIFT     = $clog2(PAGE_BYTES);
  localparam logic [31:0] STACK_SPAN     = 32'h0000_4000;
  localparam logic [31:0] SP_OFFSET      = 32'h0000_3FF0;

  // bitmap layout
  localparam int BIT_IDX_W  = 5;
  localparam int WORD_BITS  = 32;
  localparam int ACT_W      = 7;
  localparam int JOB_SLOT_W = 11;
  localparam int DIST_PAGE_W = 32 - PAGE_SHIFT;

  // defaults for the top level parameters
  localparam int DEF_BITMAP_WORDS    = 4;
  localparam int DEF_PAGES_PER_STACK = 4;

  // stream and register port widths
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;
  localparam int STATUS_W    = 2;
  localparam int SLOT_OUT_W  = 7;
  localparam int CFG_ADDR_W  = 1;
  localparam int CFG_DATA_W  = 32;
  localparam int WIU_W       = 3;

  localparam logic [CFG_ADDR_W-1:0] REG_REGION_TOP   = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_WORDS_IN_USE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    JOB_ALLOC,
    JOB_FREE,
    JOB_BAD
  } job_kind_t;

  typedef struct packed {
    job_kind_t              kind;
    logic [JOB_SLOT_W-1:0]  slot;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_EVAL,
    BK_MUL,
    BK_RES
  } back_state_t;

endpackage

// ===== rtl/core/ssba_ram.sv =====
module ssba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/ssba_front.sv =====
module ssba_front import ssba_pkg::*; #(
  parameter int PAGES_PER_STACK = DEF_PAGES_PER_STACK
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic                  in_tuser,
  input  logic [31:0]           region_top,
  input  logic [ACT_W-1:0]      act_words,
  output logic                  job_valid,
  input  logic                  job_ready,
  output job_t                  job
);

  // pointer distance / pages per stack by reciprocal multiply, exact for 20-bit dividends
  localparam int     RECIP_SHIFT = DIST_PAGE_W + $clog2(PAGES_PER_STACK);
  localparam longint RECIP       = ((longint'(1) << RECIP_SHIFT) + PAGES_PER_STACK - 1)
                                   / PAGES_PER_STACK;
  localparam int     MULT_W      = DIST_PAGE_W + 1;
  localparam int     PROD_W      = DIST_PAGE_W + MULT_W;

  logic                   s1_vld_r;
  logic                   s1_mode_r;
  logic [DIST_PAGE_W-1:0] s1_pages_r;
  logic                   s2_vld_r;
  logic                   s2_mode_r;
  logic [PROD_W-1:0]      s2_prod_r;

  logic                   s1_adv;
  logic                   s2_adv;
  logic [31:0]            ptr_gap;
  logic [MULT_W-1:0]      recip;
  logic [DIST_PAGE_W-1:0] quot;
  logic [DIST_PAGE_W-1:0] limit;
  logic                   bad;

  assign recip  = MULT_W'(RECIP);
  assign s2_adv = !s2_vld_r || job_ready;
  assign s1_adv = !s1_vld_r || s2_adv;
  assign in_tready = s1_adv;

  assign ptr_gap = region_top - in_tdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_vld_r <= in_tvalid;
      end
      if (s2_adv) begin
        s2_vld_r <= s1_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_mode_r  <= in_tuser;
      s1_pages_r <= ptr_gap[31:PAGE_SHIFT];
    end
    if (s2_adv) begin
      s2_mode_r <= s1_mode_r;
      s2_prod_r <= PROD_W'(s1_pages_r) * PROD_W'(recip);
    end
  end

  // classify: allocate, free in range, free out of range
  assign quot  = DIST_PAGE_W'(s2_prod_r >> RECIP_SHIFT);
  assign limit = DIST_PAGE_W'({act_words, {BIT_IDX_W{1'b0}}});
  assign bad   = quot >= limit;

  assign job_valid = s2_vld_r;

  always_comb begin
    job.slot = '0;
    if (!s2_mode_r) begin
      job.kind = JOB_ALLOC;
    end else if (bad) begin
      job.kind = JOB_BAD;
    end else begin
      job.kind = JOB_FREE;
      job.slot = JOB_SLOT_W'(quot);
    end
  end

endmodule

// ===== rtl/core/ssba_queue.sv =====
module ssba_queue import ssba_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_job,
  output logic pop_valid,
  input  logic pop_ready,
  output job_t pop_job
);

  job_t       ent_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       do_push;
  logic       do_pop;

  assign push_ready = cnt_r != 2'd2;
  assign pop_valid  = cnt_r != 2'd0;
  assign pop_job    = ent_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ===== rtl/core/ssba_back.sv =====
module ssba_back import ssba_pkg::*; #(
  parameter int BITMAP_WORDS    = DEF_BITMAP_WORDS,
  parameter int PAGES_PER_STACK = DEF_PAGES_PER_STACK
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [31:0]            region_top,
  input  logic [ACT_W-1:0]       act_words,
  input  logic                   job_valid,
  output logic                   job_ready,
  input  job_t                   job,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [STATUS_W-1:0]    out_tuser
);

  localparam int WIDX_W = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
  localparam int OFFS_W = JOB_SLOT_W + $clog2(PAGES_PER_STACK + 1);

  back_state_t             state_r, state_nxt;
  job_kind_t               kind_r, kind_nxt;
  logic [WIDX_W-1:0]       word_r, word_nxt;
  logic [JOB_SLOT_W-1:0]   slot_r, slot_nxt;
  status_t                 status_r, status_nxt;
  logic [OFFS_W-1:0]       offs_r;
  logic                    rd_vld_r;
  logic                    rd_row0_r;
  logic [BITMAP_WORDS-1:0] row_vld_r;
  logic                    out_valid_r;
  logic [31:0]             out_sp_r;
  logic [SLOT_OUT_W-1:0]   out_slot_r;
  status_t                 out_status_r;

  logic                    ram_re;
  logic [WIDX_W-1:0]       ram_raddr;
  logic                    ram_we;
  logic [WIDX_W-1:0]       ram_waddr;
  logic [WORD_BITS-1:0]    ram_wdata;
  logic [WORD_BITS-1:0]    ram_rdata;

  logic [WORD_BITS-1:0]    cur_word;
  logic [WORD_BITS-1:0]    zero_onehot;
  logic [BIT_IDX_W-1:0]    zero_idx;
  logic                    found;
  logic [ACT_W-1:0]        next_word;
  logic                    more;
  logic [WIDX_W-1:0]       job_widx;
  logic                    out_load;
  logic [31:0]             sp_val;

  ssba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (BITMAP_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // a row never written reads as its reset value
  assign cur_word    = rd_vld_r ? ram_rdata : {{(WORD_BITS-1){1'b0}}, rd_row0_r};
  assign zero_onehot = ~cur_word & (cur_word + 32'd1);
  assign found       = cur_word != '1;

  always_comb begin
    zero_idx = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (zero_onehot[i]) begin
        zero_idx = zero_idx | BIT_IDX_W'(i);
      end
    end
  end

  assign next_word = ACT_W'(word_r) + ACT_W'(1);
  assign more      = next_word < act_words;
  assign job_widx  = WIDX_W'(job.slot >> BIT_IDX_W);
  assign job_ready = state_r == BK_IDLE;
  assign out_load  = (state_r == BK_RES) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (job_valid) begin
          case (job.kind)
            JOB_ALLOC: state_nxt = (act_words == '0) ? BK_RES : BK_EVAL;
            JOB_FREE:  state_nxt = BK_EVAL;
            default:   state_nxt = BK_RES;
          endcase
        end
      end
      BK_EVAL: begin
        if (kind_r == JOB_ALLOC) begin
          if (found) begin
            state_nxt = BK_MUL;
          end else if (more) begin
            state_nxt = BK_EVAL;
          end else begin
            state_nxt = BK_RES;
          end
        end else begin
          state_nxt = BK_RES;
        end
      end
      BK_MUL:  state_nxt = BK_RES;
      BK_RES:  state_nxt = out_load ? BK_IDLE : BK_RES;
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    kind_nxt   = kind_r;
    word_nxt   = word_r;
    slot_nxt   = slot_r;
    status_nxt = status_r;
    ram_re     = 1'b0;
    ram_raddr  = word_r;
    ram_we     = 1'b0;
    ram_waddr  = word_r;
    ram_wdata  = cur_word;
    case (state_r)
      BK_IDLE: begin
        if (job_valid) begin
          kind_nxt   = job.kind;
          slot_nxt   = job.slot;
          status_nxt = ST_OK;
          word_nxt   = '0;
          case (job.kind)
            JOB_ALLOC: begin
              if (act_words == '0) begin
                status_nxt = ST_FULL;
                slot_nxt   = '0;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = '0;
              end
            end
            JOB_FREE: begin
              ram_re    = 1'b1;
              ram_raddr = job_widx;
              word_nxt  = job_widx;
            end
            default: begin
              status_nxt = ST_RANGE;
              slot_nxt   = '0;
            end
          endcase
        end
      end
      BK_EVAL: begin
        if (kind_r == JOB_ALLOC) begin
          if (found) begin
            ram_we    = 1'b1;
            ram_wdata = cur_word | zero_onehot;
            slot_nxt  = JOB_SLOT_W'({word_r, zero_idx});
          end else if (more) begin
            ram_re    = 1'b1;
            ram_raddr = WIDX_W'(next_word);
            word_nxt  = WIDX_W'(next_word);
          end else begin
            status_nxt = ST_FULL;
            slot_nxt   = '0;
          end
        end else begin
          ram_we    = 1'b1;
          ram_wdata = cur_word & ~(32'd1 << slot_r[BIT_IDX_W-1:0]);
        end
      end
      default: begin
      end
    endcase
  end

  // slot top = region_top - slot * slot bytes, then one stack span down
  always_comb begin
    sp_val = '0;
    if (kind_r == JOB_ALLOC && status_r == ST_OK) begin
      sp_val = ((region_top - (32'(offs_r) << PAGE_SHIFT)) - STACK_SPAN) | SP_OFFSET;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      row_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ram_we) begin
        row_vld_r[ram_waddr] <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    word_r   <= word_nxt;
    slot_r   <= slot_nxt;
    status_r <= status_nxt;
    offs_r   <= OFFS_W'(slot_r) * OFFS_W'(PAGES_PER_STACK);
    if (ram_re) begin
      rd_vld_r  <= row_vld_r[ram_raddr];
      rd_row0_r <= ram_raddr == '0;
    end
    if (out_load) begin
      out_sp_r     <= sp_val;
      out_slot_r   <= SLOT_OUT_W'(slot_r);
      out_status_r <= status_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_slot_r, out_sp_r};
  assign out_tuser  = out_status_r;

endmodule

// ===== rtl/core/stack_slot_bitmap_allocator.sv =====
// flow: a request passes the front stages s1 and s2 and the two-entry job queue, then the
//   bitmap sequencer states IDLE, EVAL (one bitmap ram read per cycle while words are scanned),
//   MUL and RES, then the output register; MUL only for an allocation that finds a free slot,
//   no EVAL for an out-of-range free; the sequencer works on one job at a time
// reset (synchronous, active low): region_top 0, words_in_use 1, slot 0 taken, others free;
//   bitmap rows are tracked by valid bits, so no clearing pass is needed
module stack_slot_bitmap_allocator import ssba_pkg::*; #(
  parameter int BITMAP_WORDS    = DEF_BITMAP_WORDS,
  parameter int PAGES_PER_STACK = DEF_PAGES_PER_STACK
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // request stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [31:0] free_pointer
  input  logic                   in_tuser,   // [0] mode: 0 allocate, 1 free
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [31:0] stack_pointer, [38:32] slot_index
  output logic [STATUS_W-1:0]    out_tuser,  // [1:0] status
  // register writes
  input  logic                   cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  logic [31:0]      region_top_r;
  logic [WIU_W-1:0] words_in_use_r;
  logic [ACT_W-1:0] wiu_ext;
  logic [ACT_W-1:0] act_words;

  job_t front_job;
  logic front_valid;
  logic front_ready;
  job_t back_job;
  logic back_valid;
  logic back_ready;

  // configuration registers; the user must write them only while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_top_r   <= '0;
      words_in_use_r <= WIU_W'(1);
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_REGION_TOP:   region_top_r   <= cfg_wdata;
        REG_WORDS_IN_USE: words_in_use_r <= cfg_wdata[WIU_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // words actually searched, clipped to the bitmap size
  assign wiu_ext   = ACT_W'(words_in_use_r);
  assign act_words = (wiu_ext > ACT_W'(BITMAP_WORDS)) ? ACT_W'(BITMAP_WORDS) : wiu_ext;

  // front: pointer to slot conversion and range check
  ssba_front #(
    .PAGES_PER_STACK (PAGES_PER_STACK)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .region_top (region_top_r),
    .act_words  (act_words),
    .job_valid  (front_valid),
    .job_ready  (front_ready),
    .job        (front_job)
  );

  // two-entry job queue decouples classification from the bitmap sequencer
  ssba_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_job   (front_job),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_job    (back_job)
  );

  // back: bitmap scan and update, stack pointer, output register
  ssba_back #(
    .BITMAP_WORDS    (BITMAP_WORDS),
    .PAGES_PER_STACK (PAGES_PER_STACK)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .region_top (region_top_r),
    .act_words  (act_words),
    .job_valid  (back_valid),
    .job_ready  (back_ready),
    .job        (back_job),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // status code 3 is never produced
  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == ST_OK || out_tuser == ST_FULL || out_tuser == ST_RANGE))
    else $error("illegal status code on result");

  // a failed request carries zero pointer and slot
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != ST_OK) |-> (out_tdata[38:0] == '0))
    else $error("failed result carries nonzero payload");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

// ===== test/tb_stack_slot_bitmap_allocator.sv =====
`timescale 1ns / 100ps

import ssba_pkg::*;

class slot_scoreboard;
  typedef struct {
    status_t     status;
    logic [31:0] sp;
    logic [6:0]  slot;
  } slot_result_t;

  localparam int SLOT_SHIFT = PAGE_SHIFT + $clog2(DEF_PAGES_PER_STACK);
  localparam bit MODE_ALLOC = 1'b0;

  bit [31:0]    bitmap[DEF_BITMAP_WORDS];
  bit [31:0]    region_top;
  bit [2:0]     words_in_use;
  slot_result_t results_due[$];
  int           errors;
  int           n_alloc, n_free, n_full, n_range, n_checked, deepest_slot;

  function new();
    foreach (bitmap[i]) bitmap[i] = '0;
    bitmap[0]    = 32'd1;  // boot stack
    region_top   = '0;
    words_in_use = 3'd1;
  endfunction

  function void set_reg(logic [CFG_ADDR_W-1:0] idx, bit [31:0] value);
    if (idx == REG_REGION_TOP) region_top = value;
    else words_in_use = value[2:0];
  endfunction

  function int pending();
    return results_due.size();
  endfunction

  // allocation or release as the block should do it, result queued in order
  function void note_request(bit mode, bit [31:0] ptr);
    slot_result_t r;
    int unsigned  n, s;
    bit           found;
    bit [31:0]    top, gap;
    r.status = ST_OK;
    r.sp     = '0;
    r.slot   = '0;
    found    = 1'b0;
    n = (words_in_use > DEF_BITMAP_WORDS) ? DEF_BITMAP_WORDS : words_in_use;
    if (mode == MODE_ALLOC) begin
      n_alloc++;
      for (int w = 0; w < n && !found; w++)
        for (int b = 0; b < 32 && !found; b++)
          if (!bitmap[w][b]) begin
            bitmap[w][b] = 1'b1;
            s      = w * 32 + b;
            top    = region_top - (32'(s) << SLOT_SHIFT);
            r.sp   = (top - STACK_SPAN) | SP_OFFSET;
            r.slot = 7'(s);
            found  = 1'b1;
            if (s > deepest_slot) deepest_slot = s;
          end
      if (!found) begin
        r.status = ST_FULL;
        n_full++;
      end
    end else begin
      n_free++;
      gap = region_top - ptr;
      s   = gap >> SLOT_SHIFT;
      if (s >= n * 32) begin
        r.status = ST_RANGE;
        n_range++;
      end else begin
        bitmap[s >> 5][s & 31] = 1'b0;
        r.slot = 7'(s);
      end
    end
    results_due.push_back(r);
  endfunction

  task report(string what);
    if (errors < 40) $display("%t mismatch: %s", $realtime, what);
    errors++;
  endtask

  task check_result(logic [STATUS_W-1:0] status, logic [OUT_TDATA_W-1:0] data);
    slot_result_t r;
    n_checked++;
    if (results_due.size() == 0) begin
      report($sformatf("unexpected result status %0d data %h", status, data));
    end else begin
      r = results_due.pop_front();
      if (status !== r.status)
        report($sformatf("status %0d, want %0d", status, r.status));
      if (data[31:0] !== r.sp)
        report($sformatf("stack_pointer %h, want %h", data[31:0], r.sp));
      if (data[38:32] !== r.slot)
        report($sformatf("slot_index %0d, want %0d", data[38:32], r.slot));
    end
  endtask
endclass

module tb_stack_slot_bitmap_allocator;

  localparam bit MODE_ALLOC  = 1'b0;
  localparam bit MODE_FREE   = 1'b1;
  localparam int NUM_PHASES  = 12;
  localparam int PHASE_ITEMS = 160;
  localparam int SETTLE      = 24;    // well above the worst alloc latency
  localparam int STALL_LIMIT = 3000;  // cycles with no handshake and no register write
  localparam int SLOT_SHIFT  = PAGE_SHIFT + $clog2(DEF_PAGES_PER_STACK);

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // [31:0] free_pointer
  logic                   in_tuser;   // [0] mode
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // [31:0] stack_pointer, [38:32] slot_index
  logic [STATUS_W-1:0]    out_tuser;  // [1:0] status
  logic                   cfg_wr_en;
  logic [CFG_ADDR_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  slot_scoreboard sb = new();

  // idling knobs, percent of cycles
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  // long receiver hold-off, loaded by the stimulus and counted down below
  int hold_len     = 0;
  int stuck_cycles = 0;

  // tb-side copy of the current settings, used only to shape pointers
  bit [31:0] cur_top = '0;
  bit [2:0]  cur_wiu = 3'd1;

  stack_slot_bitmap_allocator uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #10 clk = ~clk;

  // result side ready: random stalls, or a solid hold-off while hold_len runs
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_len > 0) begin
      out_tready <= 1'b0;
      hold_len = hold_len - 1;
    end else begin
      out_tready <= ($urandom_range(99, 0) >= rx_stall_pct);
    end
  end

  // both monitors sample the values from before this edge
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_request(in_tuser, in_tdata);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tuser, out_tdata);
  end

  // watchdog: any handshake or register write counts as progress
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en)
      stuck_cycles = 0;
    else
      stuck_cycles = stuck_cycles + 1;
    if (stuck_cycles >= STALL_LIMIT) begin
      $display("%t timeout, %0d results still due", $realtime, sb.pending());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // one item, with random sender gaps in front of it
  task send_item(bit mode, bit [31:0] ptr);
    while ($urandom_range(99, 0) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= ptr;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // register write; caller drops cfg_wr_en after the last one
  task write_reg(logic [CFG_ADDR_W-1:0] idx, bit [31:0] value);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    sb.set_reg(idx, value);
    if (idx == REG_REGION_TOP) cur_top = value;
    else cur_wiu = value[2:0];
  endtask

  task apply_settings(bit [31:0] top, bit [31:0] wiu_word);
    write_reg(REG_REGION_TOP, top);
    write_reg(REG_WORDS_IN_USE, wiu_word);
    cfg_wr_en <= 1'b0;
  endtask

  // stop offering and wait until every result is back and the block is quiet;
  // it first waits on the clock so the last accepted item is already noted
  task drain;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // pointer inside a given slot, anywhere within its 16 KiB span
  function bit [31:0] ptr_in_slot(int unsigned slot);
    return cur_top - (32'(slot) << SLOT_SHIFT) - 32'($urandom_range(16383, 0));
  endfunction

  // allocations mixed with frees at alloc_pct; most frees point into live slot range (a couple
  // of slots past the end on purpose), the rest are raw 32-bit noise
  task random_items(int count, int alloc_pct);
    bit          mode;
    bit [31:0]   ptr;
    int unsigned n;
    for (int i = 0; i < count; i++) begin
      n    = (cur_wiu > DEF_BITMAP_WORDS) ? DEF_BITMAP_WORDS : cur_wiu;
      mode = ($urandom_range(99, 0) < alloc_pct) ? MODE_ALLOC : MODE_FREE;
      ptr  = $urandom();
      if (mode == MODE_FREE && n > 0 && $urandom_range(99, 0) < 75)
        ptr = ptr_in_slot($urandom_range(n * 32 + 1, 0));
      send_item(mode, ptr);
    end
  endtask

  initial begin
    bit [31:0] top;
    bit [31:0] wiu_word;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser  <= MODE_ALLOC;
    in_tdata  <= '0;
    cfg_wr_en <= 1'b0;
    cfg_addr  <= REG_REGION_TOP;
    cfg_wdata <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings, region top 0 so pointers wrap around zero
    send_item(MODE_ALLOC, 32'h0);            // slot 1, slot 0 is the boot stack
    send_item(MODE_ALLOC, 32'hFFFF_FFFF);    // slot 2
    send_item(MODE_FREE, 32'hFFFF_C000);     // top of slot 1
    send_item(MODE_FREE, 32'hFFFF_BFF0);     // slot 1 again, freeing a free slot
    send_item(MODE_FREE, 32'h0000_4000);     // above the top, wraps far out
    send_item(MODE_FREE, 32'hFFF8_0000);     // first slot past word 0
    send_item(MODE_FREE, 32'hFFFF_FFFF);     // slot 0, releases the boot stack
    send_item(MODE_ALLOC, 32'h0);            // takes slot 0 again
    send_item(MODE_FREE, 32'h0);             // slot 0 at the very top
    drain();

    // no words in use: nothing to allocate, nothing in range
    apply_settings(32'h8000_0000, 32'd0);
    send_item(MODE_ALLOC, 32'h0);
    send_item(MODE_FREE, 32'h8000_0000);
    send_item(MODE_FREE, 32'h7FFF_FFF0);
    drain();

    // oversize word count is clamped to the bitmap depth
    apply_settings(32'hFFFF_FFFF, 32'd7);
    send_item(MODE_ALLOC, 32'h0);
    send_item(MODE_ALLOC, 32'h0);
    send_item(MODE_FREE, 32'hFFFF_FFFF);
    send_item(MODE_FREE, 32'hFFE0_0000);     // slot 127, last in range
    send_item(MODE_FREE, 32'hFFDF_FFFF);     // slot 128, just out of range
    send_item(MODE_FREE, 32'h0);
    drain();

    // random phases, each with fresh settings and its own idling style
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       top = 32'hFFFF_FFFF;
        1:       top = 32'h0;
        2:       top = 32'h0001_0000;        // top near zero, heavy wrapping
        default: top = $urandom();
      endcase
      // cycle through all word counts including zero and the clamped ones;
      // upper data bits are junk the block must ignore
      wiu_word = {$urandom_range(1, 0) ? 29'($urandom()) : 29'd0, 3'((ph * 3 + 1) % 8)};
      apply_settings(top, wiu_word);
      case (ph % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 50; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 50; end
        default: begin tx_idle_pct = 20; rx_stall_pct = 20; end
      endcase
      // long hold-off on the result side while requests keep coming,
      // so the block backs up into its input
      if (ph == 4) hold_len = 400;
      random_items(PHASE_ITEMS, (ph % 3 == 0) ? 70 : 55);
      drain();
    end

    $display("covered %0d requests: %0d allocations (%0d found no slot), %0d frees (%0d out of range)",
             sb.n_alloc + sb.n_free, sb.n_alloc, sb.n_full, sb.n_free, sb.n_range);
    $display("%0d results checked, deepest slot handed out %0d, all word counts 0..7 used",
             sb.n_checked, sb.deepest_slot);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
